// ===== rtl/mm3_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// mm3_pkg
// Shared constants, types and helpers for the 32-bit murmur3 stream hasher.
// ----------------------------------------------------------------------------
package mm3_pkg;

    // body and finalizer constants
    localparam logic [31:0] C_C1 = 32'hcc9e2d51;
    localparam logic [31:0] C_C2 = 32'h1b873593;
    localparam logic [31:0] C_N  = 32'he6546b64;
    localparam logic [31:0] C_F1 = 32'h85ebca6b;
    localparam logic [31:0] C_F2 = 32'hc2b2ae35;

    localparam int unsigned C_ROT_K = 15;
    localparam int unsigned C_ROT_H = 13;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SC1,
        ST_SC2,
        ST_MIX,
        ST_FIN0,
        ST_FIN1,
        ST_EMIT
    } t_state;

    typedef enum logic [2:0] {
        OP_NONE,
        OP_TAKE,
        OP_SC1,
        OP_SC2,
        OP_MIX,
        OP_FIN0,
        OP_FIN1,
        OP_EMIT
    } t_dp_op;

    typedef struct packed {
        logic   in_ready;
        t_dp_op op;
    } t_dp_cmd;

    typedef struct packed {
        logic word_done;  // item on the input completes a word
        logic tail_left;  // partial word pending after the item on the input
        logic out_free;   // result register can take a new result
    } t_dp_sts;

    function automatic logic [31:0] rotl32(input logic [31:0] v, input int unsigned r);
        rotl32 = (v << r) | (v >> (32 - r));
    endfunction

endpackage : mm3_pkg
`default_nettype wire

// ===== rtl/mm3_if.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// mm3_if
// Valid/ready channels for message bytes in and hash results out.
// ----------------------------------------------------------------------------
interface mm3_in_if;
    logic        valid;
    logic        ready;
    logic [7:0]  data_byte;
    logic [31:0] seed_value;
    logic        first_item;
    logic        last_item;
    logic        no_byte;

    modport source (
        output valid, data_byte, seed_value, first_item, last_item, no_byte,
        input  ready
    );
    modport sink (
        input  valid, data_byte, seed_value, first_item, last_item, no_byte,
        output ready
    );
endinterface : mm3_in_if

interface mm3_out_if;
    logic        valid;
    logic        ready;
    logic [31:0] hash_value;
    logic [31:0] message_length;

    modport source (
        output valid, hash_value, message_length,
        input  ready
    );
    modport sink (
        input  valid, hash_value, message_length,
        output ready
    );
endinterface : mm3_out_if
`default_nettype wire

// ===== rtl/mm3_datapath.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// mm3_datapath
// Hash, word, phase and length registers, shared multiplier, result register.
// ----------------------------------------------------------------------------
module mm3_datapath import mm3_pkg::*; #(
    parameter int unsigned LENGTH_BITS = 32
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire t_dp_cmd     i_cmd,
    output t_dp_sts          o_sts,
    input  wire logic [7:0]  i_data_byte,
    input  wire logic [31:0] i_seed_value,
    input  wire logic        i_first_item,
    input  wire logic        i_no_byte,
    input  wire logic        i_out_ready,
    output logic             o_out_valid,
    output logic [31:0]      o_hash_value,
    output logic [31:0]      o_message_length
);

    logic [31:0]            r_hash, n_hash;
    logic [31:0]            r_word, n_word;
    logic [1:0]             r_phase, n_phase;
    logic [LENGTH_BITS-1:0] r_len, n_len;
    logic [31:0]            r_k, n_k;
    logic                   r_out_valid, n_out_valid;
    logic [31:0]            r_out_hash, n_out_hash;
    logic [31:0]            r_out_len, n_out_len;

    logic [1:0]             phase_base;
    logic [1:0]             phase_inc;
    logic [31:0]            word_base;
    logic [31:0]            word_new;
    logic [LENGTH_BITS-1:0] len_base;
    logic [31:0]            mul_a;
    logic [31:0]            mul_b;
    logic [31:0]            mul_p;
    logic [31:0]            mix_h;
    logic [31:0]            fin_x;

    // incoming item as seen against the state it lands on
    always_comb begin
        phase_base = i_first_item ? 2'd0 : r_phase;
        word_base  = i_first_item ? 32'd0 : r_word;
        len_base   = i_first_item ? '0 : r_len;
        phase_inc  = phase_base + {1'b0, ~i_no_byte};
        word_new   = word_base;
        if (!i_no_byte) begin
            word_new = word_base | ({24'd0, i_data_byte} << {phase_base, 3'b000});
        end
    end

    assign o_sts.word_done = !i_no_byte && (phase_base == 2'd3);
    assign o_sts.tail_left = (phase_inc != 2'd0);
    assign o_sts.out_free  = !r_out_valid || i_out_ready;

    // shared multiplier
    always_comb begin
        fin_x = r_hash ^ 32'(r_len);
        mul_a = r_word;
        mul_b = C_C1;
        case (i_cmd.op)
            OP_SC2: begin
                mul_a = rotl32(r_k, C_ROT_K);
                mul_b = C_C2;
            end
            OP_FIN0: begin
                mul_a = fin_x ^ (fin_x >> 16);
                mul_b = C_F1;
            end
            OP_FIN1: begin
                mul_a = r_hash ^ (r_hash >> 13);
                mul_b = C_F2;
            end
            default: begin
                mul_a = r_word;
                mul_b = C_C1;
            end
        endcase
        mul_p = mul_a * mul_b;
        mix_h = rotl32(r_hash ^ r_k, C_ROT_H);
    end

    always_comb begin
        n_hash      = r_hash;
        n_word      = r_word;
        n_phase     = r_phase;
        n_len       = r_len;
        n_k         = r_k;
        n_out_valid = r_out_valid && !i_out_ready;
        n_out_hash  = r_out_hash;
        n_out_len   = r_out_len;
        unique case (i_cmd.op)
            OP_NONE: begin
            end
            OP_TAKE: begin
                n_hash  = i_first_item ? i_seed_value : r_hash;
                n_word  = word_new;
                n_phase = phase_inc;
                n_len   = len_base + {{(LENGTH_BITS-1){1'b0}}, ~i_no_byte};
            end
            OP_SC1, OP_SC2: begin
                n_k = mul_p;
            end
            OP_MIX: begin
                if (r_phase == 2'd0) begin
                    // full word: rotate, times five plus constant
                    n_hash = (mix_h << 2) + mix_h + C_N;
                    n_word = 32'd0;
                end else begin
                    // tail bytes: no rotate-and-add
                    n_hash = r_hash ^ r_k;
                end
            end
            OP_FIN0, OP_FIN1: begin
                n_hash = mul_p;
            end
            OP_EMIT: begin
                n_out_valid = 1'b1;
                n_out_hash  = r_hash ^ (r_hash >> 16);
                n_out_len   = 32'(r_len);
                n_hash      = 32'd0;
                n_word      = 32'd0;
                n_phase     = 2'd0;
                n_len       = '0;
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hash      <= 32'd0;
            r_word      <= 32'd0;
            r_phase     <= 2'd0;
            r_len       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_hash      <= n_hash;
            r_word      <= n_word;
            r_phase     <= n_phase;
            r_len       <= n_len;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_k        <= n_k;
        r_out_hash <= n_out_hash;
        r_out_len  <= n_out_len;
    end

    assign o_out_valid      = r_out_valid;
    assign o_hash_value     = r_out_hash;
    assign o_message_length = r_out_len;

endmodule : mm3_datapath
`default_nettype wire

// ===== rtl/mm3_ctrl.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// mm3_ctrl
// Sequencer for word mixing, tail mixing and finalization.
// ----------------------------------------------------------------------------
module mm3_ctrl import mm3_pkg::*; (
    input  wire logic    i_clk,
    input  wire logic    i_rst_n,
    input  wire logic    i_in_valid,
    input  wire logic    i_last_item,
    input  wire t_dp_sts i_sts,
    output t_dp_cmd      o_cmd
);

    t_state r_state, n_state;
    logic   r_last, n_last;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_last  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_last  <= n_last;
        end
    end

    always_comb begin
        n_state         = r_state;
        n_last          = r_last;
        o_cmd.in_ready  = 1'b0;
        o_cmd.op        = OP_NONE;
        unique case (r_state)
            ST_IDLE: begin
                o_cmd.in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.op = OP_TAKE;
                    n_last   = i_last_item;
                    if (i_sts.word_done) begin
                        n_state = ST_SC1;
                    end else if (i_last_item) begin
                        n_state = i_sts.tail_left ? ST_SC1 : ST_FIN0;
                    end
                end
            end
            ST_SC1: begin
                o_cmd.op = OP_SC1;
                n_state  = ST_SC2;
            end
            ST_SC2: begin
                o_cmd.op = OP_SC2;
                n_state  = ST_MIX;
            end
            ST_MIX: begin
                o_cmd.op = OP_MIX;
                n_state  = r_last ? ST_FIN0 : ST_IDLE;
            end
            ST_FIN0: begin
                o_cmd.op = OP_FIN0;
                n_state  = ST_FIN1;
            end
            ST_FIN1: begin
                o_cmd.op = OP_FIN1;
                n_state  = ST_EMIT;
            end
            ST_EMIT: begin
                if (i_sts.out_free) begin
                    o_cmd.op = OP_EMIT;
                    n_last   = 1'b0;
                    n_state  = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

endmodule : mm3_ctrl
`default_nettype wire

// ===== rtl/murmur3_32_stream_hasher_top.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// murmur3_32_stream_hasher_top
// 32-bit murmur3 over a byte stream, one byte per transaction, one hash per
// message.
// ----------------------------------------------------------------------------
//  channel    | dir | interface         | payload
//  i_item     | in  | mm3_in_if.sink    | data_byte, seed_value, first_item,
//             |     |                   | last_item, no_byte
//  o_result   | out | mm3_out_if.source | hash_value, message_length
//
//  a byte that does not complete a word is only accepted; a byte that
//  completes a word goes through accept, two constant multiplies and hash mix,
//  the multiplies through the one shared 32x32 multiplier in the datapath
//  a last transaction first mixes any word or tail bytes left, then runs the
//  fmix32 steps FIN0 and FIN1 and the emit into the result register
//  reset clears control, hash and result-valid state at once; no clearing pass
//  the result register holds a finished hash while the sink stalls; the next
//  message is accepted meanwhile, and only the final emit step waits on it
// ----------------------------------------------------------------------------
module murmur3_32_stream_hasher_top import mm3_pkg::*; #(
    parameter int unsigned LENGTH_BITS = 32   // length counter width, 8..32
) (
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    mm3_in_if.sink     i_item,
    mm3_out_if.source  o_result
);

    t_dp_cmd cmd;   // controller to datapath
    t_dp_sts sts;   // datapath to controller

    // the controller only accepts in its idle state
    assign i_item.ready = cmd.in_ready;

    mm3_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_item.valid),
        .i_last_item (i_item.last_item),
        .i_sts       (sts),
        .o_cmd       (cmd)
    );

    // hash state, the shared multiplier and the result register
    mm3_datapath #(
        .LENGTH_BITS (LENGTH_BITS)
    ) u_dp (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cmd            (cmd),
        .o_sts            (sts),
        .i_data_byte      (i_item.data_byte),
        .i_seed_value     (i_item.seed_value),
        .i_first_item     (i_item.first_item),
        .i_no_byte        (i_item.no_byte),
        .i_out_ready      (o_result.ready),
        .o_out_valid      (o_result.valid),
        .o_hash_value     (o_result.hash_value),
        .o_message_length (o_result.message_length)
    );

endmodule : murmur3_32_stream_hasher_top
`default_nettype wire

// ===== rtl/mm3_checker.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// mm3_checker
// Port-level checks on the hasher, attached to the top level by bind.
// ----------------------------------------------------------------------------
module mm3_checker (
    input wire logic        i_clk,
    input wire logic        i_rst_n,
    input wire logic        i_in_valid,
    input wire logic        i_in_ready,
    input wire logic        i_in_last,
    input wire logic        i_out_valid,
    input wire logic        i_out_ready,
    input wire logic [31:0] i_out_hash,
    input wire logic [31:0] i_out_len
);

    // a pending result stays until taken
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && !i_out_ready) |=> i_out_valid)
        else $error("result dropped while stalled");

    // a stalled result keeps its payload
    a_out_stable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && !i_out_ready) |=> ($stable(i_out_hash) && $stable(i_out_len)))
        else $error("result payload changed while stalled");

    // finalization keeps the input closed right after a last transaction
    a_busy_after_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && i_in_ready && i_in_last) |=> !i_in_ready)
        else $error("input open right after a last transaction");

    // no fresh result appears the cycle after an input transaction
    a_no_instant_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && i_in_ready) |=>
            !(i_out_valid && (!$past(i_out_valid) || $past(i_out_ready))))
        else $error("result emitted while the input was being accepted");

endmodule : mm3_checker

bind murmur3_32_stream_hasher_top mm3_checker u_mm3_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_item.valid),
    .i_in_ready  (i_item.ready),
    .i_in_last   (i_item.last_item),
    .i_out_valid (o_result.valid),
    .i_out_ready (o_result.ready),
    .i_out_hash  (o_result.hash_value),
    .i_out_len   (o_result.message_length)
);
`default_nettype wire

// ===== tb/tb_top.sv =====
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the murmur3 stream hasher: a table of hand-picked
// messages, then random messages under changing back-pressure, each hash
// checked against a hand-typed result or a cycle-free model kept in the bench.
// ----------------------------------------------------------------------------
module tb_top;

    // ------------------------------------------------------------------------
    // constants of the hash and of the run
    // ------------------------------------------------------------------------
    localparam int unsigned LEN_BITS = 32;
    localparam logic [31:0] LEN_MASK = 32'((64'd1 << LEN_BITS) - 64'd1);

    localparam logic [31:0] K_C1 = 32'hcc9e2d51;
    localparam logic [31:0] K_C2 = 32'h1b873593;
    localparam logic [31:0] K_N  = 32'he6546b64;
    localparam logic [31:0] K_F1 = 32'h85ebca6b;
    localparam logic [31:0] K_F2 = 32'hc2b2ae35;

    localparam int N_DIRECTED   = 25;
    localparam int N_RANDOM     = 500;
    localparam int HOLD_CYCLES  = 400;   // long sink stall to fill the block
    localparam int STALL_LIMIT  = 4000;  // cycles with no transaction at all
    localparam int DRAIN_CYCLES = 20;    // quiet wait after the drain for stray results

    // one input transaction
    typedef struct packed {
        logic [7:0]  octet;
        logic [31:0] seed;
        logic        first;
        logic        last;
        logic        nob;
    } t_msg_item;

    // one hash the block owes us
    typedef struct packed {
        logic [31:0] hash;
        logic [31:0] len;
    } t_digest;

    // directed row: item plus an optional hand-typed result
    typedef struct packed {
        logic [7:0]  octet;
        logic [31:0] seed;
        logic        first;
        logic        last;
        logic        nob;
        logic        typed;
        logic [31:0] hash;
        logic [31:0] len;
    } t_row;

    // ------------------------------------------------------------------------
    // clock, reset, channels and the block
    // ------------------------------------------------------------------------
    logic clk = 1'b0;
    logic rst_n;

    always #5 clk = ~clk;

    mm3_in_if  item_if ();
    mm3_out_if result_if ();

    murmur3_32_stream_hasher_top #(
        .LENGTH_BITS (LEN_BITS)
    ) dut (
        .i_clk    (clk),
        .i_rst_n  (rst_n),
        .i_item   (item_if),
        .o_result (result_if)
    );

    // ------------------------------------------------------------------------
    // bench state
    // ------------------------------------------------------------------------
    int unsigned src_idle_pct = 13;
    int unsigned snk_idle_pct = 78;
    bit          hold_req     = 1'b0;

    // hand-typed result riding along with the item being driven
    logic        tag_typed;
    logic [31:0] tag_hash;
    logic [31:0] tag_len;

    t_digest     pending_digests[$];
    t_row        dir_rows[N_DIRECTED];

    int unsigned mismatches      = 0;
    int unsigned digests_checked = 0;
    int unsigned items_taken     = 0;
    int unsigned bytes_taken     = 0;
    int unsigned longest_msg     = 0;
    int unsigned random_items    = 0;
    int unsigned stall_cycles    = 0;

    // model of the hash state
    logic [31:0] h_acc;
    logic [31:0] w_acc;
    logic [1:0]  phase;
    logic [31:0] len_cnt;

    // ------------------------------------------------------------------------
    // hash model
    // ------------------------------------------------------------------------

    // k * c1, rotate left 15, * c2
    function automatic logic [31:0] scramble_word(input logic [31:0] k);
        logic [31:0] t;
        t = k * K_C1;
        t = {t[16:0], t[31:17]};
        return t * K_C2;
    endfunction

    // take one item; returns 1 and the digest when the item ends a message
    function automatic bit murmur_absorb(input t_msg_item it,
                                         output logic [31:0] digest,
                                         output logic [31:0] nbytes);
        logic [31:0] h;
        digest = '0;
        nbytes = '0;
        if (it.first) begin
            h_acc   = it.seed;
            w_acc   = '0;
            phase   = '0;
            len_cnt = '0;
        end
        if (!it.nob) begin
            w_acc   = w_acc | ({24'd0, it.octet} << (8 * phase));
            phase   = phase + 2'd1;
            len_cnt = (len_cnt + 32'd1) & LEN_MASK;
            // fourth byte closes a little-endian word
            if (phase == 2'd0) begin
                h_acc = h_acc ^ scramble_word(w_acc);
                h_acc = {h_acc[18:0], h_acc[31:19]};
                h_acc = h_acc * 32'd5 + K_N;
                w_acc = '0;
            end
        end
        if (!it.last)
            return 1'b0;
        // tail bytes skip the rotate-and-add step
        h = h_acc;
        if (phase != 2'd0)
            h = h ^ scramble_word(w_acc);
        // length in, then fmix32
        h = h ^ len_cnt;
        h = h ^ (h >> 16);
        h = h * K_F1;
        h = h ^ (h >> 13);
        h = h * K_F2;
        h = h ^ (h >> 16);
        digest  = h;
        nbytes  = len_cnt & LEN_MASK;
        h_acc   = '0;
        w_acc   = '0;
        phase   = '0;
        len_cnt = '0;
        return 1'b1;
    endfunction

    // ------------------------------------------------------------------------
    // stimulus helpers
    // ------------------------------------------------------------------------
    function automatic t_msg_item mk_item(input logic [7:0] o, input logic [31:0] s,
                                          input bit f, input bit l, input bit n);
        t_msg_item it;
        it = '{o, s, f, l, n};
        return it;
    endfunction

    // drive one transaction from a falling edge, return at the falling edge
    // after it was accepted; valid stays high into back-to-back items
    task automatic send_item(input t_msg_item it, input bit typed,
                             input logic [31:0] thash, input logic [31:0] tlen);
        while ($urandom_range(99) < src_idle_pct) begin
            item_if.valid <= 1'b0;
            @(negedge clk);
        end
        item_if.valid      <= 1'b1;
        item_if.data_byte  <= it.octet;
        item_if.seed_value <= it.seed;
        item_if.first_item <= it.first;
        item_if.last_item  <= it.last;
        item_if.no_byte    <= it.nob;
        tag_typed          <= typed;
        tag_hash           <= thash;
        tag_len            <= tlen;
        @(posedge clk);
        while (!item_if.ready)
            @(posedge clk);
        @(negedge clk);
    endtask

    // items the block only ignores do not count toward the random budget
    task automatic send_counted(input t_msg_item it);
        send_item(it, 1'b0, '0, '0);
        if (!(it.nob && !it.first && !it.last))
            random_items++;
    endtask

    // one random message: mostly well formed, some with the first item
    // missing, some cut off without a last item, some pure noise
    task automatic send_random_message();
        int unsigned kind;
        int unsigned nbytes;
        int unsigned k;
        logic [31:0] seed;
        bit          missing_first;
        bit          truncated;
        bit          trailing_last;
        kind          = $urandom_range(99);
        missing_first = (kind >= 80) && (kind < 90);
        truncated     = (kind >= 90) && (kind < 95);
        if (kind >= 95) begin
            // noise: fully random flags and fields
            repeat ($urandom_range(3, 1))
                send_counted(mk_item(8'($urandom_range(255)), $urandom,
                                     1'($urandom_range(1)), 1'($urandom_range(1)),
                                     1'($urandom_range(1))));
            return;
        end
        // mostly short messages, a few long ones
        nbytes = ($urandom_range(9) == 0) ? $urandom_range(64) : $urandom_range(12);
        case ($urandom_range(9))
            0: seed = '0;
            1: seed = '1;
            default: seed = $urandom;
        endcase
        trailing_last = (nbytes == 0) || ($urandom_range(4) == 0);
        for (k = 0; k < nbytes; k++) begin
            // byte-less gap inside the message
            if (k > 0 && $urandom_range(9) == 0)
                send_counted(mk_item(8'($urandom_range(255)), $urandom,
                                     1'b0, 1'b0, 1'b1));
            send_counted(mk_item(8'($urandom_range(255)), (k == 0) ? seed : $urandom,
                                 (k == 0) && !missing_first,
                                 (k == nbytes - 1) && !trailing_last && !truncated,
                                 1'b0));
        end
        // closing item without a byte; also the empty message
        if (trailing_last && !truncated)
            send_counted(mk_item(8'($urandom_range(255)), seed,
                                 (nbytes == 0) && !missing_first, 1'b1, 1'b1));
    endtask

    // ------------------------------------------------------------------------
    // result sink: random ready, plus one long hold on request
    // ------------------------------------------------------------------------
    initial begin : sink
        int hold_left;
        hold_left       = 0;
        result_if.ready = 1'b0;
        forever begin
            @(negedge clk);
            if (hold_req) begin
                hold_req  = 1'b0;
                hold_left = HOLD_CYCLES;
            end
            if (hold_left > 0) begin
                result_if.ready <= 1'b0;
                hold_left--;
            end else begin
                result_if.ready <= ($urandom_range(99) >= snk_idle_pct);
            end
        end
    end

    // ------------------------------------------------------------------------
    // monitor: model on accepted items, compare on accepted results,
    // watchdog on stretches with no transaction
    // ------------------------------------------------------------------------
    always @(posedge clk) begin : monitor
        t_msg_item   seen;
        t_digest     want;
        logic [31:0] dg;
        logic [31:0] nb;
        bit          moved;
        moved = 1'b0;
        if (rst_n) begin
            if (item_if.valid && item_if.ready) begin
                moved = 1'b1;
                seen  = '{item_if.data_byte, item_if.seed_value, item_if.first_item,
                          item_if.last_item, item_if.no_byte};
                items_taken++;
                if (!seen.nob)
                    bytes_taken++;
                if (murmur_absorb(seen, dg, nb)) begin
                    // a typed row overrides the model's answer
                    if (tag_typed)
                        pending_digests.push_back('{tag_hash, tag_len});
                    else
                        pending_digests.push_back('{dg, nb});
                end
            end
            if (result_if.valid && result_if.ready) begin
                moved = 1'b1;
                if (pending_digests.size() == 0) begin
                    mismatches++;
                    $error("unexpected result: hash_value %h message_length %0d",
                           result_if.hash_value, result_if.message_length);
                end else begin
                    want = pending_digests.pop_front();
                    digests_checked++;
                    if (want.len > longest_msg)
                        longest_msg = want.len;
                    if (result_if.hash_value !== want.hash) begin
                        mismatches++;
                        $error("hash_value: expected %h, got %h",
                               want.hash, result_if.hash_value);
                    end
                    if (result_if.message_length !== want.len) begin
                        mismatches++;
                        $error("message_length: expected %0d, got %0d",
                               want.len, result_if.message_length);
                    end
                end
            end
            stall_cycles = moved ? 0 : stall_cycles + 1;
            if (stall_cycles >= STALL_LIMIT) begin
                $display("watchdog: no transaction for %0d cycles, %0d results pending",
                         STALL_LIMIT, pending_digests.size());
                $display("RESULT: ERROR");
                $finish;
            end
        end
    end

    // ------------------------------------------------------------------------
    // main sequence
    // ------------------------------------------------------------------------
    initial begin : main
        int i;

        // known values on every input from time zero
        rst_n              = 1'b0;
        item_if.valid      = 1'b0;
        item_if.data_byte  = '0;
        item_if.seed_value = '0;
        item_if.first_item = 1'b0;
        item_if.last_item  = 1'b0;
        item_if.no_byte    = 1'b0;
        tag_typed          = 1'b0;
        tag_hash           = '0;
        tag_len            = '0;
        h_acc              = '0;
        w_acc              = '0;
        phase              = '0;
        len_cnt            = '0;

        // octet, seed, first, last, no byte, typed, hash, length
        dir_rows = '{
            // empty message, zero seed: fmix32 of zero is zero
            '{8'h00, 32'h00000000, 1'b1, 1'b1, 1'b1, 1'b1, 32'h0, 32'd0},
            // empty message, all-ones seed
            '{8'h5a, 32'hffffffff, 1'b1, 1'b1, 1'b1, 1'b0, 32'h0, 32'd0},
            // single-item messages, both byte extremes
            '{8'h00, 32'h00000000, 1'b1, 1'b1, 1'b0, 1'b0, 32'h0, 32'd0},
            '{8'hff, 32'hffffffff, 1'b1, 1'b1, 1'b0, 1'b0, 32'h0, 32'd0},
            // one full word of ones, no tail
            '{8'hff, 32'hffffffff, 1'b1, 1'b0, 1'b0, 1'b0, 32'h0, 32'd0},
            '{8'hff, 32'h00000000, 1'b0, 1'b0, 1'b0, 1'b0, 32'h0, 32'd0},
            '{8'hff, 32'h00000000, 1'b0, 1'b0, 1'b0, 1'b0, 32'h0, 32'd0},
            '{8'hff, 32'h00000000, 1'b0, 1'b1, 1'b0, 1'b0, 32'h0, 32'd0},
            // five bytes with a byte-less gap, one-byte tail
            '{8'h01, 32'ha5a5a5a5, 1'b1, 1'b0, 1'b0, 1'b0, 32'h0, 32'd0},
            '{8'h3c, 32'h12345678, 1'b0, 1'b0, 1'b1, 1'b0, 32'h0, 32'd0},
            '{8'h80, 32'h00000000, 1'b0, 1'b0, 1'b0, 1'b0, 32'h0, 32'd0},
            '{8'h7f, 32'h00000000, 1'b0, 1'b0, 1'b0, 1'b0, 32'h0, 32'd0},
            '{8'h00, 32'h00000000, 1'b0, 1'b0, 1'b0, 1'b0, 32'h0, 32'd0},
            '{8'h55, 32'h00000000, 1'b0, 1'b1, 1'b0, 1'b0, 32'h0, 32'd0},
            // three-byte tail, closed by a last item without a byte
            '{8'h12, 32'h0f0f0f0f, 1'b1, 1'b0, 1'b0, 1'b0, 32'h0, 32'd0},
            '{8'h34, 32'h00000000, 1'b0, 1'b0, 1'b0, 1'b0, 32'h0, 32'd0},
            '{8'h56, 32'h00000000, 1'b0, 1'b0, 1'b0, 1'b0, 32'h0, 32'd0},
            '{8'h00, 32'h00000000, 1'b0, 1'b1, 1'b1, 1'b0, 32'h0, 32'd0},
            // no first item: continues from the cleared state
            '{8'haa, 32'h00000000, 1'b0, 1'b0, 1'b0, 1'b0, 32'h0, 32'd0},
            '{8'hbb, 32'h00000000, 1'b0, 1'b1, 1'b0, 1'b0, 32'h0, 32'd0},
            // message restarted by a second first item
            '{8'h11, 32'hdeadbeef, 1'b1, 1'b0, 1'b0, 1'b0, 32'h0, 32'd0},
            '{8'h22, 32'h00000000, 1'b0, 1'b0, 1'b0, 1'b0, 32'h0, 32'd0},
            '{8'h33, 32'h00000001, 1'b1, 1'b0, 1'b0, 1'b0, 32'h0, 32'd0},
            '{8'h44, 32'h00000000, 1'b0, 1'b1, 1'b0, 1'b0, 32'h0, 32'd0},
            // bare last with no open message: seed zero, nothing hashed
            '{8'h00, 32'hffffffff, 1'b0, 1'b1, 1'b1, 1'b1, 32'h0, 32'd0}
        };

        // synchronous reset, released on a falling edge
        repeat (6) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // directed table, sender light and sink heavy idling
        for (i = 0; i < N_DIRECTED; i++)
            send_item(mk_item(dir_rows[i].octet, dir_rows[i].seed, dir_rows[i].first,
                              dir_rows[i].last, dir_rows[i].nob),
                      dir_rows[i].typed, dir_rows[i].hash, dir_rows[i].len);

        // random messages in three idling phases
        while (random_items < N_RANDOM) begin
            if (random_items >= 2 * N_RANDOM / 3) begin
                if (src_idle_pct != 0 || snk_idle_pct != 0)
                    hold_req = 1'b1;   // sink stalls long while items keep coming
                src_idle_pct = 0;
                snk_idle_pct = 0;
            end else if (random_items >= N_RANDOM / 3) begin
                src_idle_pct = 78;
                snk_idle_pct = 13;
            end
            send_random_message();
        end
        item_if.valid <= 1'b0;

        // drain: every hash in, then a few quiet cycles for strays
        while (pending_digests.size() != 0)
            @(negedge clk);
        repeat (DRAIN_CYCLES) @(negedge clk);

        $display("run covered %0d transactions, %0d message bytes, %0d hashes checked",
                 items_taken, bytes_taken, digests_checked);
        $display("longest message %0d bytes, %0d mismatches", longest_msg, mismatches);
        if (mismatches == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule : tb_top
